[hw/rtl/sat_pkg.sv]
package sat_pkg;

    // default buffer size in bytes
    localparam int LINE_LENGTH = 128;

    // argument count stops here
    localparam logic [7:0] ARG_LIMIT = 8'd128;

    // characters with a meaning to the parser
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NUL       = 8'h00;

    // parser modes; the fourth code behaves as search
    typedef enum logic [1:0] {
        MODE_SEARCH = 2'd0,
        MODE_PLAIN  = 2'd1,
        MODE_QUOTED = 2'd2
    } sat_mode_t;

    // parser control state, write position kept apart
    typedef struct packed {
        sat_mode_t  mode;
        logic       escape;
        logic [7:0] args;
        logic       overflow;
    } sat_ctl_t;

    // one result as it leaves the step logic, index kept apart
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic [7:0] args;
        logic       line_end;
        logic       overflow;
    } sat_res_t;

endpackage

[hw/rtl/sat_step.sv]
module sat_step #(
    parameter int LINE_LENGTH = sat_pkg::LINE_LENGTH
) (
    input  sat_pkg::sat_ctl_t                     ctl,
    input  logic [$clog2(LINE_LENGTH + 1) - 1:0]  pos,
    input  logic [7:0]                            ch,
    output sat_pkg::sat_ctl_t                     ctl_next,
    output logic [$clog2(LINE_LENGTH + 1) - 1:0]  pos_next,
    output sat_pkg::sat_res_t                     res,
    output logic [$clog2(LINE_LENGTH + 1) - 1:0]  res_pos
);

    localparam int POS_W = $clog2(LINE_LENGTH + 1);
    localparam logic [POS_W - 1:0] POS_FULL = POS_W'(LINE_LENGTH);
    localparam logic [POS_W - 1:0] POS_LAST = POS_W'(LINE_LENGTH - 1);

    logic             do_store;
    logic [7:0]       store_byte;
    sat_pkg::sat_ctl_t mid;

    // mode update, decides whether a byte goes to the buffer
    always_comb begin
        mid        = ctl;
        do_store   = 1'b0;
        store_byte = ch;
        case (ctl.mode)
            sat_pkg::MODE_PLAIN, sat_pkg::MODE_QUOTED: begin
                if (ctl.escape) begin
                    mid.escape = 1'b0;
                    do_store   = 1'b1;
                end else if (ch == sat_pkg::CH_BACKSLASH) begin
                    mid.escape = 1'b1;
                end else if (ch == sat_pkg::CH_QUOTE) begin
                    mid.mode = (ctl.mode == sat_pkg::MODE_QUOTED) ?
                               sat_pkg::MODE_PLAIN : sat_pkg::MODE_QUOTED;
                end else if (ch == sat_pkg::CH_SPACE && ctl.mode == sat_pkg::MODE_PLAIN) begin
                    mid.mode   = sat_pkg::MODE_SEARCH;
                    do_store   = 1'b1;
                    store_byte = sat_pkg::CH_NUL;
                end else begin
                    do_store = 1'b1;
                end
            end
            default: begin
                mid.mode = sat_pkg::MODE_SEARCH;
                if (ch != sat_pkg::CH_SPACE) begin
                    if (ctl.args < sat_pkg::ARG_LIMIT) begin
                        mid.args = ctl.args + 8'd1;
                    end
                    if (ch == sat_pkg::CH_QUOTE) begin
                        mid.mode = sat_pkg::MODE_QUOTED;
                    end else if (ch == sat_pkg::CH_BACKSLASH) begin
                        mid.mode   = sat_pkg::MODE_PLAIN;
                        mid.escape = 1'b1;
                    end else begin
                        mid.mode = sat_pkg::MODE_PLAIN;
                        do_store = 1'b1;
                    end
                end
            end
        endcase
    end

    // buffer write, line end and overflow handling
    always_comb begin
        ctl_next     = mid;
        pos_next     = pos;
        res_pos      = pos;
        res.valid    = 1'b0;
        res.data     = store_byte;
        res.args     = mid.args;
        res.line_end = 1'b0;
        res.overflow = mid.overflow;
        if (ch == sat_pkg::CH_NEWLINE || ch == sat_pkg::CH_RETURN) begin
            // terminator overwrites the last byte on a full buffer
            res.valid    = 1'b1;
            res.data     = sat_pkg::CH_NUL;
            res.args     = ctl.args;
            res.line_end = 1'b1;
            res.overflow = ctl.overflow;
            if (pos >= POS_FULL) begin
                res_pos      = POS_LAST;
                res.overflow = 1'b1;
            end
            ctl_next.mode     = sat_pkg::MODE_SEARCH;
            ctl_next.escape   = 1'b0;
            ctl_next.args     = 8'd0;
            ctl_next.overflow = 1'b0;
            pos_next          = '0;
        end else if (do_store) begin
            if (pos >= POS_FULL) begin
                ctl_next.overflow = 1'b1;
            end else begin
                res.valid = 1'b1;
                pos_next  = pos + POS_W'(1);
            end
        end
    end

endmodule

[hw/rtl/shell_argument_tokenizer_unit.sv]
// channel  | direction | handshake         | payload
// s_       | in        | s_valid / s_ready | s_in_byte
// m_       | out       | m_valid / m_ready | m_out_byte, m_out_index, m_arg_count,
//          |           |                   | m_line_end, m_overflow
//
// one item accepted per cycle while s_ready is high; its result, if any, is registered and shows in the next cycle
// the rate is set by the combinational mode update feeding the result register
// s_ready is low only while a result waits and m_ready is low
// synchronous active-low reset returns the parser to search with an empty buffer
module shell_argument_tokenizer_unit #(
    parameter int LINE_LENGTH = sat_pkg::LINE_LENGTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [6:0] m_out_index,
    output logic [7:0] m_arg_count,
    output logic       m_line_end,
    output logic       m_overflow
);

    localparam int POS_W = $clog2(LINE_LENGTH + 1);
    localparam int IDX_W = (POS_W > 7) ? POS_W : 7;

    sat_pkg::sat_ctl_t  ctl_reg;
    sat_pkg::sat_ctl_t  ctl_next;
    logic [POS_W - 1:0] pos_reg;
    logic [POS_W - 1:0] pos_next;
    sat_pkg::sat_res_t  res;
    logic [POS_W - 1:0] res_pos;
    logic [IDX_W - 1:0] res_idx_wide;

    logic       m_valid_reg;
    logic [7:0] out_byte_reg;
    logic [6:0] out_index_reg;
    logic [7:0] arg_count_reg;
    logic       line_end_reg;
    logic       overflow_reg;
    logic       accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // per-character parse step
    sat_step #(
        .LINE_LENGTH(LINE_LENGTH)
    ) u_step (
        .ctl      (ctl_reg),
        .pos      (pos_reg),
        .ch       (s_in_byte),
        .ctl_next (ctl_next),
        .pos_next (pos_next),
        .res      (res),
        .res_pos  (res_pos)
    );

    // buffer index is reported in its low seven bits
    assign res_idx_wide = IDX_W'(res_pos);

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.mode     <= sat_pkg::MODE_SEARCH;
            ctl_reg.escape   <= 1'b0;
            ctl_reg.args     <= 8'd0;
            ctl_reg.overflow <= 1'b0;
            pos_reg          <= '0;
        end else if (accept) begin
            ctl_reg <= ctl_next;
            pos_reg <= pos_next;
        end
    end

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= res.valid;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (accept && res.valid) begin
            out_byte_reg  <= res.data;
            out_index_reg <= res_idx_wide[6:0];
            arg_count_reg <= res.args;
            line_end_reg  <= res.line_end;
            overflow_reg  <= res.overflow;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = out_byte_reg;
    assign m_out_index = out_index_reg;
    assign m_arg_count = arg_count_reg;
    assign m_line_end  = line_end_reg;
    assign m_overflow  = overflow_reg;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    // kinds of command line the random part builds
    typedef enum int {
        LINE_WORDS,
        LINE_NOISE,
        LINE_BROKEN,
        LINE_MANY_ARGS,
        LINE_LONG_WORD,
        LINE_FULL_WORD
    } line_kind_t;

    // one byte written to the argument buffer, as the result channel shows it
    typedef struct {
        logic [7:0] data;
        logic [6:0] index;
        logic [7:0] args;
        logic       line_end;
        logic       ovf;
    } stored_byte_t;

    // tokenizer state mirror plus the queue of bytes still to come out
    class token_ledger;
        sat_pkg::sat_mode_t mode;
        logic               escape;
        logic [7:0]         args;
        int                 wpos;
        logic               ovf;
        stored_byte_t       stored_q[$];
        int                 fails;

        function new();
            clear_line();
            fails = 0;
        endfunction

        function void clear_line();
            mode   = sat_pkg::MODE_SEARCH;
            escape = 1'b0;
            args   = 8'd0;
            wpos   = 0;
            ovf    = 1'b0;
        endfunction

        function void push_byte(logic [7:0] data, int idx, logic line_end);
            stored_byte_t e;
            e.data     = data;
            e.index    = 7'(idx);
            e.args     = args;
            e.line_end = line_end;
            e.ovf      = ovf;
            stored_q.push_back(e);
        endfunction

        // buffer write; past the end the byte is dropped and flagged
        function void store(logic [7:0] data);
            if (wpos >= sat_pkg::LINE_LENGTH) begin
                ovf = 1'b1;
            end else begin
                push_byte(data, wpos, 1'b0);
                wpos++;
            end
        endfunction

        // advance the parser by one accepted item
        function void note_char(logic [7:0] ch);
            int idx;
            // newline or return always closes the line
            if (ch == sat_pkg::CH_NEWLINE || ch == sat_pkg::CH_RETURN) begin
                idx = wpos;
                if (idx >= sat_pkg::LINE_LENGTH) begin
                    idx = sat_pkg::LINE_LENGTH - 1;
                    ovf = 1'b1;
                end
                push_byte(sat_pkg::CH_NUL, idx, 1'b1);
                clear_line();
                return;
            end
            // inside an argument
            if (mode == sat_pkg::MODE_QUOTED || mode == sat_pkg::MODE_PLAIN) begin
                if (escape) begin
                    escape = 1'b0;
                    store(ch);
                end else if (ch == sat_pkg::CH_BACKSLASH) begin
                    escape = 1'b1;
                end else if (ch == sat_pkg::CH_QUOTE) begin
                    mode = (mode == sat_pkg::MODE_QUOTED) ? sat_pkg::MODE_PLAIN
                                                          : sat_pkg::MODE_QUOTED;
                end else if (ch == sat_pkg::CH_SPACE && mode == sat_pkg::MODE_PLAIN) begin
                    mode = sat_pkg::MODE_SEARCH;
                    store(sat_pkg::CH_NUL);
                end else begin
                    store(ch);
                end
                return;
            end
            // searching: anything but a space begins an argument
            mode = sat_pkg::MODE_SEARCH;
            if (ch == sat_pkg::CH_SPACE)
                return;
            if (args < sat_pkg::ARG_LIMIT)
                args++;
            if (ch == sat_pkg::CH_QUOTE) begin
                mode = sat_pkg::MODE_QUOTED;
                return;
            end
            mode = sat_pkg::MODE_PLAIN;
            if (ch == sat_pkg::CH_BACKSLASH)
                escape = 1'b1;
            else
                store(ch);
        endfunction

        // compare one result item with the oldest stored byte
        function void check_stored(logic [7:0] data, logic [6:0] index, logic [7:0] cnt,
                                   logic line_end, logic ovf_out);
            stored_byte_t e;
            if (stored_q.size() == 0) begin
                $error("result item with nothing pending: out_byte %0h index %0d",
                       data, index);
                fails++;
                return;
            end
            e = stored_q.pop_front();
            if (data !== e.data) begin
                $error("out_byte: expected %0h, got %0h", e.data, data);
                fails++;
            end
            if (index !== e.index) begin
                $error("out_index: expected %0d, got %0d", e.index, index);
                fails++;
            end
            if (cnt !== e.args) begin
                $error("arg_count: expected %0d, got %0d", e.args, cnt);
                fails++;
            end
            if (line_end !== e.line_end) begin
                $error("line_end: expected %0b, got %0b", e.line_end, line_end);
                fails++;
            end
            if (ovf_out !== e.ovf) begin
                $error("overflow: expected %0b, got %0b", e.ovf, ovf_out);
                fails++;
            end
        endfunction
    endclass

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'd0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [7:0] m_out_byte;
    logic [6:0] m_out_index;
    logic [7:0] m_arg_count;
    logic       m_line_end;
    logic       m_overflow;

    token_ledger ledger;
    logic [7:0]  char_q[$];

    shell_argument_tokenizer_unit #(
        .LINE_LENGTH(sat_pkg::LINE_LENGTH)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_index(m_out_index),
        .m_arg_count(m_arg_count),
        .m_line_end (m_line_end),
        .m_overflow (m_overflow)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // any byte that has no meaning to the parser
    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == sat_pkg::CH_NEWLINE || c == sat_pkg::CH_RETURN ||
                   c == sat_pkg::CH_SPACE || c == sat_pkg::CH_QUOTE ||
                   c == sat_pkg::CH_BACKSLASH);
        return c;
    endfunction

    // any byte that a backslash may make literal
    function automatic logic [7:0] escaped_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == sat_pkg::CH_NEWLINE || c == sat_pkg::CH_RETURN);
        return c;
    endfunction

    function automatic logic [7:0] line_term();
        return ($urandom_range(0, 1) == 1) ? sat_pkg::CH_NEWLINE : sat_pkg::CH_RETURN;
    endfunction

    // one argument made of plain, escaped and quoted pieces
    task automatic add_token();
        int pieces;
        int n;
        pieces = $urandom_range(1, 8);
        repeat (pieces) begin
            case ($urandom_range(0, 5))
                0: begin
                    char_q.push_back(sat_pkg::CH_BACKSLASH);
                    char_q.push_back(escaped_char());
                end
                1: begin
                    char_q.push_back(sat_pkg::CH_QUOTE);
                    n = $urandom_range(0, 6);
                    repeat (n) begin
                        case ($urandom_range(0, 3))
                            0: char_q.push_back(sat_pkg::CH_SPACE);
                            1: begin
                                char_q.push_back(sat_pkg::CH_BACKSLASH);
                                char_q.push_back(escaped_char());
                            end
                            default: char_q.push_back(word_char());
                        endcase
                    end
                    char_q.push_back(sat_pkg::CH_QUOTE);
                end
                default: char_q.push_back(word_char());
            endcase
        end
    endtask

    task automatic add_line(line_kind_t kind);
        int n;
        case (kind)
            LINE_WORDS, LINE_BROKEN: begin
                repeat ($urandom_range(0, 2)) char_q.push_back(sat_pkg::CH_SPACE);
                n = $urandom_range(1, 6);
                repeat (n) begin
                    add_token();
                    repeat ($urandom_range(1, 3)) char_q.push_back(sat_pkg::CH_SPACE);
                end
                // broken lines stop on a lone backslash or an open quote
                if (kind == LINE_BROKEN) begin
                    if ($urandom_range(0, 1) == 1) begin
                        add_token();
                        char_q.push_back(sat_pkg::CH_BACKSLASH);
                    end else begin
                        char_q.push_back(sat_pkg::CH_QUOTE);
                        repeat ($urandom_range(0, 4)) char_q.push_back(word_char());
                    end
                end
            end
            LINE_NOISE: begin
                repeat ($urandom_range(1, 20)) char_q.push_back(8'($urandom_range(0, 255)));
            end
            LINE_MANY_ARGS: begin
                // more than the count limit of one-byte arguments
                repeat (sat_pkg::ARG_LIMIT + 4) begin
                    char_q.push_back(word_char());
                    char_q.push_back(sat_pkg::CH_SPACE);
                end
            end
            LINE_LONG_WORD: begin
                repeat (sat_pkg::LINE_LENGTH + 12) begin
                    if ($urandom_range(0, 7) == 0) begin
                        char_q.push_back(sat_pkg::CH_BACKSLASH);
                        char_q.push_back(escaped_char());
                    end else begin
                        char_q.push_back(word_char());
                    end
                end
            end
            LINE_FULL_WORD: begin
                // fills the buffer exactly, so the terminator lands on the last slot
                repeat (sat_pkg::LINE_LENGTH) char_q.push_back(word_char());
            end
            default: ;
        endcase
        char_q.push_back(line_term());
    endtask

    // sender: bursts of items with random gaps in between
    task automatic send_chars();
        int burst;
        int gap;
        burst = 0;
        foreach (char_q[i]) begin
            if (burst == 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    burst = $urandom_range(40, 80);
                    gap   = 0;
                end else begin
                    burst = $urandom_range(1, 16);
                    gap   = $urandom_range(0, 4);
                end
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            s_valid   <= 1'b1;
            s_in_byte <= char_q[i];
            do @(posedge aclk); while (!s_ready);
            ledger.note_char(char_q[i]);
            burst--;
            @(negedge aclk);
        end
        s_valid <= 1'b0;
    endtask

    // receiver stall pattern, redrawn repeatedly, sometimes never stalling
    logic [15:0] stall_pat  = 16'hFFFF;
    int          stall_step = 0;

    always @(negedge aclk) begin
        if (stall_step % 96 == 0)
            stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                    : (16'($urandom) | 16'h0001);
        m_ready <= stall_pat[stall_step % 16];
        stall_step++;
    end

    // result check on every accepted result item
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            ledger.check_stored(m_out_byte, m_out_index, m_arg_count, m_line_end,
                                m_overflow);
    end

    initial begin
        int         line_no;
        line_kind_t kind;
        ledger = new();

        // directed: a leading space, a quote opening an argument and closing mid-argument,
        // escaped space, backslash right before the line end, zero and 0xff
        // bytes, backslash starting an argument, return inside quotes, empty line
        char_q = {sat_pkg::CH_SPACE, "a", "b", sat_pkg::CH_SPACE, sat_pkg::CH_QUOTE,
                  "c", sat_pkg::CH_SPACE, "d", sat_pkg::CH_QUOTE,
                  "e", sat_pkg::CH_BACKSLASH, sat_pkg::CH_SPACE, "f",
                  sat_pkg::CH_BACKSLASH, sat_pkg::CH_NEWLINE,
                  sat_pkg::CH_NUL, 8'hFF, sat_pkg::CH_SPACE, sat_pkg::CH_BACKSLASH,
                  "q", "x", sat_pkg::CH_QUOTE, sat_pkg::CH_SPACE,
                  sat_pkg::CH_RETURN, sat_pkg::CH_NEWLINE};

        // random lines, long ones placed early among the ordinary ones
        line_no = 0;
        while (char_q.size() < 500 || line_no < 6) begin
            case (line_no)
                1: kind = LINE_MANY_ARGS;
                3: kind = LINE_LONG_WORD;
                5: kind = LINE_FULL_WORD;
                default: begin
                    case ($urandom_range(0, 9))
                        0, 1: kind = LINE_NOISE;
                        2, 3: kind = LINE_BROKEN;
                        default: kind = LINE_WORDS;
                    endcase
                end
            endcase
            add_line(kind);
            line_no++;
        end

        // reset held low at start, then released on a falling edge
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_chars();

        // drain, then wait for anything stray
        while (ledger.stored_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (ledger.fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // timeout
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
